[hw/rtl/leg_command_supervisor_top_assert.svh]
// Assertion macros for the leg command supervisor.
// Used by leg_command_supervisor_top; expects i_clk and i_rst_n in scope.
`ifndef LEG_COMMAND_SUPERVISOR_TOP_ASSERT_SVH
`define LEG_COMMAND_SUPERVISOR_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LCS_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("leg command supervisor assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define LCS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("leg command supervisor assertion failed");

`endif

[hw/rtl/lcs_pkg.sv]
// Package of the leg command supervisor: item types, codes and the state rules.
// No dependencies; used by every module of the block.
`default_nettype none

package lcs_pkg;

    localparam int JOINT_COUNT = 12;
    localparam int JW          = 4;

    localparam logic [30:0] TRQ_BOUND_RST    = 31'd1048576;
    localparam logic [9:0]  MAX_REPEAT_RST   = 10'd20;
    localparam logic [30:0] DAMPING_GAIN_RST = 31'd327680;
    localparam logic [9:0]  REPEAT_MAX       = 10'd1023;

    typedef enum logic [3:0] {
        CMD_TICK  = 4'd0,
        CMD_CMDEL = 4'd1,
        CMD_MEAS  = 4'd2,
        CMD_HOLD  = 4'd3,
        CMD_HDFLT = 4'd4,
        CMD_DAMP  = 4'd5,
        CMD_EMERG = 4'd6,
        CMD_MODE  = 4'd7,
        CMD_DFLT  = 4'd8
    } t_cmd;

    typedef enum logic [2:0] {
        CFG_TRQ_BOUND    = 3'd0,
        CFG_MAX_REPEAT   = 3'd1,
        CFG_DAMPING_GAIN = 3'd2,
        CFG_HOLD_GAIN_P  = 3'd3,
        CFG_HOLD_GAIN_D  = 3'd4
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_WAIT    = 3'd0,
        ST_OPERATE = 3'd1,
        ST_DAMPING = 3'd2,
        ST_HOLD    = 3'd3,
        ST_EMERG   = 3'd4
    } t_state;

    typedef enum logic [2:0] {
        JOB_REPLY,
        JOB_PASS,
        JOB_TORQUE,
        JOB_DAMP,
        JOB_HOLD
    } t_jkind;

    typedef enum logic [2:0] {
        WR_CMD,
        WR_MEAS,
        WR_HOLD,
        WR_DFLT,
        WR_COPY
    } t_wsel;

    typedef struct packed {
        logic [3:0]         command;
        logic [3:0]         joint_index;
        logic               last_element;
        logic signed [31:0] position;
        logic signed [31:0] velocity;
        logic [30:0]        gain_p;
        logic [30:0]        gain_d;
        logic signed [31:0] effort;
        logic [1:0]         req_mode;
    } t_in_item;

    typedef struct packed {
        logic               kind;
        logic [3:0]         out_joint;
        logic signed [31:0] out_position;
        logic signed [31:0] out_velocity;
        logic [30:0]        out_gain_p;
        logic [30:0]        out_gain_d;
        logic signed [31:0] out_effort;
        logic               last_joint;
        logic               success;
        logic               mode_now;
        logic [2:0]         machine_state;
    } t_out_item;

    typedef struct packed {
        logic [30:0] trq_bound;
        logic [9:0]  max_repeat;
        logic [30:0] damping_gain;
        logic [30:0] hold_gain_p;
        logic [30:0] hold_gain_d;
    } t_cfg;

    typedef struct packed {
        t_jkind kind;
        logic   ok;
        logic   mode;
        t_state st;
    } t_job;

    typedef struct packed {
        logic     en;
        t_wsel    sel;
        t_in_item d;
    } t_wr;

    typedef struct packed {
        logic   ok;
        t_state nxt;
        logic   clr;
    } t_go;

    // State transition rules of a request; clr asks to drop command_seen.
    function automatic t_go go_state(t_state cur, t_state tgt);
        t_go g;
        g.ok  = 1'b1;
        g.nxt = cur;
        g.clr = 1'b0;
        if (tgt == cur) begin
            g.ok = 1'b1;
        end else if (tgt == ST_EMERG) begin
            g.nxt = ST_EMERG;
        end else if ((cur == ST_EMERG && tgt != ST_DAMPING) ||
                     (cur == ST_WAIT && tgt == ST_DAMPING) || tgt == ST_WAIT) begin
            g.ok = 1'b0;
        end else begin
            g.nxt = tgt;
            g.clr = (tgt == ST_DAMPING) || (tgt == ST_HOLD);
        end
        return g;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/leg_command_supervisor_top.sv]
// Top level of the leg command supervisor: configuration registers, front end,
// job queue and back end. Depends on lcs_pkg and the assertion macro header.
`default_nettype none

// Twelve-joint safety supervisor. Element writes, requests and ticks enter as
// input beats; a tick in an emitting state yields twelve joint beats, one per
// cycle once its job reaches the back end and the output is not stalled, and each
// request yields one reply beat through the read, multiply, sum and clamp stages.
// The front end holds state, mode and watchdog and takes a tick or request while
// the two-entry job queue has room; element writes wait until the queue is empty
// and the back end has finished reading the joint stores. Emitting ticks are
// limited by the twelve reads on the single store read port and by the back end
// taking the next job only once it is idle.
// Configuration writes through i_cfg_we take effect at once.
module leg_command_supervisor_top (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  lcs_pkg::t_in_item    i_in_data,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output lcs_pkg::t_out_item   o_out_data,
    input  wire                  i_cfg_we,
    input  wire [2:0]            i_cfg_idx,
    input  wire [30:0]           i_cfg_data
);
    import lcs_pkg::*;

    t_cfg r_cfg;
    t_job push_job, q_job;
    t_wr  wr;
    logic push, pop, q_empty, q_full, back_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.trq_bound    <= TRQ_BOUND_RST;
            r_cfg.max_repeat   <= MAX_REPEAT_RST;
            r_cfg.damping_gain <= DAMPING_GAIN_RST;
            r_cfg.hold_gain_p  <= '0;
            r_cfg.hold_gain_d  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TRQ_BOUND:    r_cfg.trq_bound    <= i_cfg_data;
                CFG_MAX_REPEAT:   r_cfg.max_repeat   <= i_cfg_data[9:0];
                CFG_DAMPING_GAIN: r_cfg.damping_gain <= i_cfg_data;
                CFG_HOLD_GAIN_P:  r_cfg.hold_gain_p  <= i_cfg_data;
                CFG_HOLD_GAIN_D:  r_cfg.hold_gain_d  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    lcs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_max_repeat(r_cfg.max_repeat),
        .i_q_full    (q_full),
        .i_q_empty   (q_empty),
        .i_back_busy (back_busy),
        .o_push      (push),
        .o_job       (push_job),
        .o_wr        (wr)
    );

    lcs_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data (push_job),
        .i_pop  (pop),
        .o_data (q_job),
        .o_empty(q_empty),
        .o_full (q_full)
    );

    lcs_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_wr       (wr),
        .i_job      (q_job),
        .i_q_empty  (q_empty),
        .o_pop      (pop),
        .o_busy     (back_busy),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

`include "leg_command_supervisor_top_assert.svh"

    `LCS_ASSERT_SAME(a_write_when_idle, wr.en, q_empty && !back_busy)
    `LCS_ASSERT_SAME(a_no_overflow, push, !q_full)
    `LCS_ASSERT_SAME(a_last_joint, o_out_valid && o_out_data.last_joint,
        !o_out_data.kind && o_out_data.out_joint == 4'd11)
    `LCS_ASSERT_NEXT(a_pop_starts_job, pop, back_busy)

endmodule

`default_nettype wire

[hw/rtl/lcs_queue.sv]
// Two-entry job queue between the supervisor front and the emission back end.
// Depends on lcs_pkg for the job type.
`default_nettype none

module lcs_queue (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  lcs_pkg::t_job    i_data,
    input  wire              i_pop,
    output lcs_pkg::t_job    o_data,
    output logic             o_empty,
    output logic             o_full
);
    import lcs_pkg::*;

    t_job       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

    assign o_data  = r_mem[r_rp];
    assign o_empty = (r_cnt == 2'd0);
    assign o_full  = (r_cnt == 2'd2);

endmodule

`default_nettype wire

[hw/rtl/lcs_front.sv]
// Front end: accepts input beats, runs watchdog and state rules, writes the joint
// stores and queues emission jobs. Depends on lcs_pkg.
`default_nettype none

module lcs_front (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_ready,
    input  lcs_pkg::t_in_item i_in_data,
    input  wire [9:0]        i_max_repeat,
    input  wire              i_q_full,
    input  wire              i_q_empty,
    input  wire              i_back_busy,
    output logic             o_push,
    output lcs_pkg::t_job    o_job,
    output lcs_pkg::t_wr     o_wr
);
    import lcs_pkg::*;

    t_state     r_state, n_state;
    logic       r_mode, n_mode;
    logic [9:0] r_rc, n_rc;
    logic       r_cs, n_cs;
    logic       r_ms, n_ms;
    logic       is_write;
    logic       acc;
    logic       idx_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_WAIT;
            r_mode  <= 1'b0;
            r_rc    <= 10'd0;
            r_cs    <= 1'b0;
            r_ms    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
            r_rc    <= n_rc;
            r_cs    <= n_cs;
            r_ms    <= n_ms;
        end
    end

    // Store writes wait until no queued or running job can still read the stores.
    always_comb begin
        is_write = (i_in_data.command == CMD_CMDEL) || (i_in_data.command == CMD_MEAS) ||
                   (i_in_data.command == CMD_HOLD) || (i_in_data.command == CMD_HDFLT) ||
                   (i_in_data.command == CMD_DFLT);
        o_in_ready = !i_q_full && (!is_write || (i_q_empty && !i_back_busy));
        acc = i_in_valid && o_in_ready;
        idx_ok = (i_in_data.joint_index < JW'(JOINT_COUNT));
    end

    always_comb begin
        t_go g;
        g = '0;
        n_state = r_state;
        n_mode  = r_mode;
        n_rc    = r_rc;
        n_cs    = r_cs;
        n_ms    = r_ms;
        o_push  = 1'b0;
        o_job.kind = JOB_REPLY;
        o_job.ok   = 1'b0;
        o_wr.en  = 1'b0;
        o_wr.sel = WR_CMD;
        o_wr.d   = i_in_data;
        if (acc) begin
            unique case (i_in_data.command)
                CMD_TICK: begin
                    if (r_state == ST_OPERATE) begin
                        if (r_rc >= i_max_repeat) begin
                            g = go_state(r_state, ST_DAMPING);
                            n_state = g.nxt;
                            n_cs = 1'b0;
                        end else begin
                            o_push = 1'b1;
                            o_job.kind = r_mode ? JOB_TORQUE : JOB_PASS;
                            if (r_rc != REPEAT_MAX) n_rc = r_rc + 10'd1;
                        end
                    end else if (r_state != ST_EMERG && r_cs && r_ms) begin
                        n_state = ST_OPERATE;
                    end else if (r_state == ST_HOLD) begin
                        o_push = 1'b1;
                        o_job.kind = JOB_HOLD;
                    end else if (r_state != ST_WAIT) begin
                        o_push = 1'b1;
                        o_job.kind = JOB_DAMP;
                    end
                end
                CMD_CMDEL: begin
                    o_wr.en  = idx_ok;
                    o_wr.sel = WR_CMD;
                    if (i_in_data.last_element) begin
                        n_cs = 1'b1;
                        n_rc = 10'd0;
                    end
                end
                CMD_MEAS: begin
                    o_wr.en  = idx_ok;
                    o_wr.sel = WR_MEAS;
                    if (i_in_data.last_element) n_ms = 1'b1;
                end
                CMD_HOLD, CMD_HDFLT: begin
                    o_wr.en  = (i_in_data.command == CMD_HDFLT) || idx_ok;
                    o_wr.sel = (i_in_data.command == CMD_HDFLT) ? WR_COPY : WR_HOLD;
                    if (i_in_data.command == CMD_HDFLT || i_in_data.last_element) begin
                        g = go_state(r_state, ST_HOLD);
                        n_state = g.nxt;
                        if (g.clr) n_cs = 1'b0;
                        o_push = 1'b1;
                        o_job.ok = g.ok;
                    end
                end
                CMD_DAMP, CMD_EMERG: begin
                    g = go_state(r_state,
                                 (i_in_data.command == CMD_DAMP) ? ST_DAMPING : ST_EMERG);
                    n_state = g.nxt;
                    if (g.clr) n_cs = 1'b0;
                    o_push = 1'b1;
                    o_job.ok = g.ok;
                end
                CMD_MODE: begin
                    o_push = 1'b1;
                    if (!i_in_data.req_mode[1]) begin
                        n_mode = i_in_data.req_mode[0];
                        o_job.ok = 1'b1;
                        if (r_state == ST_OPERATE || r_state == ST_EMERG) begin
                            g = go_state(r_state, ST_DAMPING);
                            n_state = g.nxt;
                            if (g.clr) n_cs = 1'b0;
                            o_job.ok = g.ok;
                        end
                    end
                end
                CMD_DFLT: begin
                    o_wr.en  = idx_ok;
                    o_wr.sel = WR_DFLT;
                end
                default: begin
                    o_push = 1'b0;
                end
            endcase
        end
        // Joint items and replies both report mode and state after the beat.
        o_job.mode = n_mode;
        o_job.st   = n_state;
    end

endmodule

`default_nettype wire

[hw/rtl/lcs_back.sv]
// Back end: holds the joint stores and runs a three-stage emission pipeline
// (store read, PD products, sum and clamp). Depends on lcs_pkg.
`default_nettype none

module lcs_back (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  lcs_pkg::t_cfg     i_cfg,
    input  lcs_pkg::t_wr      i_wr,
    input  lcs_pkg::t_job     i_job,
    input  wire               i_q_empty,
    output logic              o_pop,
    output logic              o_busy,
    output logic              o_out_valid,
    input  wire               i_out_ready,
    output lcs_pkg::t_out_item o_out_data
);
    import lcs_pkg::*;

    logic signed [31:0] r_dpos [JOINT_COUNT];
    logic signed [31:0] r_dvel [JOINT_COUNT];
    logic [30:0]        r_dkp  [JOINT_COUNT];
    logic [30:0]        r_dkd  [JOINT_COUNT];
    logic signed [31:0] r_deff [JOINT_COUNT];
    logic signed [31:0] r_mpos [JOINT_COUNT];
    logic signed [31:0] r_mvel [JOINT_COUNT];
    logic signed [31:0] r_hold [JOINT_COUNT];
    logic signed [31:0] r_dflt [JOINT_COUNT];

    logic               r_busy;
    t_job               r_job;
    logic [JW-1:0]      r_cnt;
    logic               adv;
    logic               issue;
    logic               done;

    // Stage one: the item with its joint fields; stage two adds the products.
    logic               r_v1, r_v2, r_ov;
    t_out_item          r1_it, r2_it, r_out;
    logic               r1_tq, r2_tq;
    logic [30:0]        r1_kp, r1_kd;
    logic signed [32:0] r1_dp, r1_dv;
    logic signed [64:0] r2_p1, r2_p2;
    t_out_item          s1;
    t_out_item          s3;
    logic signed [65:0] sum;
    logic signed [65:0] lim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < JOINT_COUNT; k++) r_dflt[k] <= '0;
        end else if (i_wr.en && i_wr.sel == WR_DFLT) begin
            r_dflt[i_wr.d.joint_index] <= i_wr.d.position;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            unique case (i_wr.sel)
                WR_CMD: begin
                    r_dpos[i_wr.d.joint_index] <= i_wr.d.position;
                    r_dvel[i_wr.d.joint_index] <= i_wr.d.velocity;
                    r_dkp[i_wr.d.joint_index]  <= i_wr.d.gain_p;
                    r_dkd[i_wr.d.joint_index]  <= i_wr.d.gain_d;
                    r_deff[i_wr.d.joint_index] <= i_wr.d.effort;
                end
                WR_MEAS: begin
                    r_mpos[i_wr.d.joint_index] <= i_wr.d.position;
                    r_mvel[i_wr.d.joint_index] <= i_wr.d.velocity;
                end
                WR_HOLD: r_hold[i_wr.d.joint_index] <= i_wr.d.position;
                WR_COPY: for (int k = 0; k < JOINT_COUNT; k++) r_hold[k] <= r_dflt[k];
                default: ;
            endcase
        end
    end

    assign adv   = !r_ov || i_out_ready;
    assign issue = r_busy && adv;
    assign done  = (r_job.kind == JOB_REPLY) || (r_cnt == JW'(JOINT_COUNT - 1));
    assign o_pop = !r_busy && !i_q_empty;
    assign o_busy = r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (issue) begin
            if (done) r_busy <= 1'b0;
            r_cnt <= r_cnt + JW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_job <= i_job;
    end

    always_comb begin
        s1 = '0;
        s1.kind          = (r_job.kind == JOB_REPLY);
        s1.success       = (r_job.kind == JOB_REPLY) && r_job.ok;
        s1.mode_now      = r_job.mode;
        s1.machine_state = r_job.st;
        if (r_job.kind != JOB_REPLY) begin
            s1.out_joint  = r_cnt;
            s1.last_joint = (r_cnt == JW'(JOINT_COUNT - 1));
        end
        case (r_job.kind)
            JOB_PASS: begin
                s1.out_position = r_dpos[r_cnt];
                s1.out_velocity = r_dvel[r_cnt];
                s1.out_gain_p   = r_dkp[r_cnt];
                s1.out_gain_d   = r_dkd[r_cnt];
                s1.out_effort   = r_deff[r_cnt];
            end
            JOB_TORQUE: s1.out_effort = r_deff[r_cnt];
            JOB_DAMP:   s1.out_gain_d = i_cfg.damping_gain;
            JOB_HOLD: begin
                s1.out_position = r_hold[r_cnt];
                s1.out_gain_p   = i_cfg.hold_gain_p;
                s1.out_gain_d   = i_cfg.hold_gain_d;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_ov <= 1'b0;
        end else if (adv) begin
            r_v1 <= issue;
            r_v2 <= r_v1;
            r_ov <= r_v2;
        end
    end

    // The difference of two 32-bit values always fits 33 bits.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_it <= s1;
            r1_tq <= (r_job.kind == JOB_TORQUE);
            r1_kp <= r_dkp[r_cnt];
            r1_kd <= r_dkd[r_cnt];
            r1_dp <= 33'(r_dpos[r_cnt]) - 33'(r_mpos[r_cnt]);
            r1_dv <= 33'(r_dvel[r_cnt]) - 33'(r_mvel[r_cnt]);
            r2_it <= r1_it;
            r2_tq <= r1_tq;
            r2_p1 <= $signed({2'b00, r1_kp}) * 65'(r1_dp);
            r2_p2 <= $signed({2'b00, r1_kd}) * 65'(r1_dv);
            r_out <= s3;
        end
    end

    // Arithmetic shift right gives the floor of the Q16.16 product.
    always_comb begin
        lim = $signed({35'd0, i_cfg.trq_bound});
        sum = 66'(r2_it.out_effort) + 66'(r2_p1 >>> 16) + 66'(r2_p2 >>> 16);
        s3  = r2_it;
        if (r2_tq) begin
            if (sum > lim)       s3.out_effort = 32'(lim);
            else if (sum < -lim) s3.out_effort = 32'(-lim);
            else                 s3.out_effort = 32'(sum);
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

[test/leg_command_supervisor_top_tb.sv]
// Self-checking testbench of the leg command supervisor top level.
// Depends on lcs_pkg and leg_command_supervisor_top; predicts every beat in place.
`timescale 1ns / 100ps

module leg_command_supervisor_top_tb;
    import lcs_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in_item    i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_item   o_out_data;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [30:0] i_cfg_data = '0;

    leg_command_supervisor_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // Supervisor shadow: configuration, state and joint stores.
    logic [30:0] sh_trq_bound = TRQ_BOUND_RST;
    logic [9:0]  sh_max_repeat = MAX_REPEAT_RST;
    logic [30:0] sh_damp_gain = DAMPING_GAIN_RST;
    logic [30:0] sh_hold_kp = '0;
    logic [30:0] sh_hold_kd = '0;
    t_state      sh_state = ST_WAIT;
    logic        sh_mode = 1'b0;
    logic [9:0]  sh_repeat = '0;
    logic        sh_cmd_seen = 1'b0;
    logic        sh_meas_seen = 1'b0;
    logic signed [31:0] des_pos[JOINT_COUNT], des_vel[JOINT_COUNT], des_eff[JOINT_COUNT];
    logic [30:0]        des_kp[JOINT_COUNT], des_kd[JOINT_COUNT];
    logic signed [31:0] meas_pos[JOINT_COUNT], meas_vel[JOINT_COUNT];
    logic signed [31:0] hold_pos[JOINT_COUNT];
    logic signed [31:0] dflt_pos[JOINT_COUNT] = '{default: '0};

    t_in_item  pending_beats[$];
    t_out_item expected_beats[$];
    int        errors = 0;
    int        cycles = 0;
    logic      in_taken = 1'b0;
    int        in_gap = 0;
    int        ready_gap = 0;
    int        long_hold = 0;
    logic      long_hold_req = 1'b0;
    logic      long_hold_done = 1'b0;
    logic      no_idle = 1'b0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (no_idle || r < 65) return 0;
        if (r < 95) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    function automatic void push_beat(logic kind, int j, logic [31:0] p, logic [31:0] v,
                                      logic [30:0] kp, logic [30:0] kd, logic [31:0] e,
                                      logic last, logic ok);
        t_out_item o;
        o.kind = kind;
        o.out_joint = j[3:0];
        o.out_position = p;
        o.out_velocity = v;
        o.out_gain_p = kp;
        o.out_gain_d = kd;
        o.out_effort = e;
        o.last_joint = last;
        o.success = ok;
        o.mode_now = sh_mode;
        o.machine_state = sh_state;
        expected_beats.push_back(o);
    endfunction

    function automatic logic request_state(t_state tgt);
        if (tgt == sh_state) return 1'b1;
        if (tgt == ST_EMERG) begin
            sh_state = ST_EMERG;
            return 1'b1;
        end
        if ((sh_state == ST_EMERG && tgt != ST_DAMPING) ||
            (sh_state == ST_WAIT && tgt == ST_DAMPING) || tgt == ST_WAIT)
            return 1'b0;
        sh_state = tgt;
        if (tgt == ST_DAMPING || tgt == ST_HOLD) sh_cmd_seen = 1'b0;
        return 1'b1;
    endfunction

    function automatic logic [31:0] joint_torque(int j);
        longint dp, dv, t, lim;
        dp = longint'(des_pos[j]) - longint'(meas_pos[j]);
        dv = longint'(des_vel[j]) - longint'(meas_vel[j]);
        // Arithmetic shift of a signed product rounds toward minus infinity.
        t = longint'(des_eff[j]) + ((longint'(des_kp[j]) * dp) >>> 16)
            + ((longint'(des_kd[j]) * dv) >>> 16);
        lim = longint'(sh_trq_bound);
        if (t > lim) t = lim;
        if (t < -lim) t = -lim;
        return t[31:0];
    endfunction

    function automatic void emit_tick();
        for (int j = 0; j < JOINT_COUNT; j++) begin
            if (sh_state == ST_OPERATE && !sh_mode)
                push_beat(1'b0, j, des_pos[j], des_vel[j], des_kp[j], des_kd[j], des_eff[j],
                          j == JOINT_COUNT - 1, 1'b0);
            else if (sh_state == ST_OPERATE)
                push_beat(1'b0, j, '0, '0, '0, '0, joint_torque(j), j == JOINT_COUNT - 1, 1'b0);
            else if (sh_state == ST_HOLD)
                push_beat(1'b0, j, hold_pos[j], '0, sh_hold_kp, sh_hold_kd, '0,
                          j == JOINT_COUNT - 1, 1'b0);
            else
                push_beat(1'b0, j, '0, '0, '0, sh_damp_gain, '0, j == JOINT_COUNT - 1, 1'b0);
        end
    endfunction

    function automatic void supervise(t_in_item it);
        logic in_range;
        int   j;
        logic ok;
        in_range = it.joint_index < JOINT_COUNT;
        j = in_range ? int'(it.joint_index) : 0;
        case (it.command)
            CMD_TICK: begin
                if (sh_state == ST_OPERATE) begin
                    if (sh_repeat >= sh_max_repeat) begin
                        ok = request_state(ST_DAMPING);
                    end else begin
                        emit_tick();
                        if (sh_repeat != REPEAT_MAX) sh_repeat++;
                    end
                end else if (sh_state != ST_EMERG && sh_cmd_seen && sh_meas_seen) begin
                    ok = request_state(ST_OPERATE);
                end else if (sh_state != ST_WAIT) begin
                    emit_tick();
                end
            end
            CMD_CMDEL: begin
                if (in_range) begin
                    des_pos[j] = it.position;
                    des_vel[j] = it.velocity;
                    des_kp[j] = it.gain_p;
                    des_kd[j] = it.gain_d;
                    des_eff[j] = it.effort;
                end
                if (it.last_element) begin
                    sh_cmd_seen = 1'b1;
                    sh_repeat = '0;
                end
            end
            CMD_MEAS: begin
                if (in_range) begin
                    meas_pos[j] = it.position;
                    meas_vel[j] = it.velocity;
                end
                if (it.last_element) sh_meas_seen = 1'b1;
            end
            CMD_HOLD: begin
                if (in_range) hold_pos[j] = it.position;
                if (it.last_element) begin
                    ok = request_state(ST_HOLD);
                    push_beat(1'b1, 0, '0, '0, '0, '0, '0, 1'b0, ok);
                end
            end
            CMD_HDFLT: begin
                hold_pos = dflt_pos;
                ok = request_state(ST_HOLD);
                push_beat(1'b1, 0, '0, '0, '0, '0, '0, 1'b0, ok);
            end
            CMD_DAMP: begin
                ok = request_state(ST_DAMPING);
                push_beat(1'b1, 0, '0, '0, '0, '0, '0, 1'b0, ok);
            end
            CMD_EMERG: begin
                ok = request_state(ST_EMERG);
                push_beat(1'b1, 0, '0, '0, '0, '0, '0, 1'b0, ok);
            end
            CMD_MODE: begin
                if (it.req_mode > 2'd1) begin
                    ok = 1'b0;
                end else begin
                    sh_mode = it.req_mode[0];
                    ok = 1'b1;
                    if (sh_state == ST_OPERATE || sh_state == ST_EMERG)
                        ok = request_state(ST_DAMPING);
                end
                push_beat(1'b1, 0, '0, '0, '0, '0, '0, 1'b0, ok);
            end
            CMD_DFLT: if (in_range) dflt_pos[j] = it.position;
            default: ;
        endcase
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("[%0d] mismatch %s: got %h expected %h", cycles, what, got, want);
        errors++;
    endtask

    // Input side: accepted beats update the shadow at the rising edge.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        in_taken <= i_in_valid && o_in_ready;
        if (i_rst_n && i_in_valid && o_in_ready) supervise(i_in_data);
        if (i_rst_n && i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_TRQ_BOUND:    sh_trq_bound = i_cfg_data;
                CFG_MAX_REPEAT:   sh_max_repeat = i_cfg_data[9:0];
                CFG_DAMPING_GAIN: sh_damp_gain = i_cfg_data;
                CFG_HOLD_GAIN_P:  sh_hold_kp = i_cfg_data;
                CFG_HOLD_GAIN_D:  sh_hold_kd = i_cfg_data;
                default: ;
            endcase
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (in_gap > 0) begin
                i_in_valid <= 1'b0;
                in_gap <= in_gap - 1;
            end else if (pending_beats.size() > 0) begin
                i_in_data <= pending_beats.pop_front();
                i_in_valid <= 1'b1;
                in_gap <= pick_gap();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Output side: ready with random stalls and one long hold-off.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (long_hold > 0) begin
            i_out_ready <= 1'b0;
            long_hold <= long_hold - 1;
        end else if (long_hold_req && !long_hold_done) begin
            i_out_ready <= 1'b0;
            long_hold <= 600;
            long_hold_done <= 1'b1;
        end else if (ready_gap > 0) begin
            i_out_ready <= 1'b0;
            ready_gap <= ready_gap - 1;
        end else begin
            i_out_ready <= 1'b1;
            ready_gap <= pick_gap();
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_beats.size() == 0) begin
                report("unexpected beat kind", 32'(o_out_data.kind), 32'd0);
            end else begin
                t_out_item w;
                w = expected_beats.pop_front();
                if (o_out_data.kind !== w.kind)
                    report("kind", 32'(o_out_data.kind), 32'(w.kind));
                if (o_out_data.out_joint !== w.out_joint)
                    report("out_joint", 32'(o_out_data.out_joint), 32'(w.out_joint));
                if (o_out_data.out_position !== w.out_position)
                    report("out_position", o_out_data.out_position, w.out_position);
                if (o_out_data.out_velocity !== w.out_velocity)
                    report("out_velocity", o_out_data.out_velocity, w.out_velocity);
                if (o_out_data.out_gain_p !== w.out_gain_p)
                    report("out_gain_p", 32'(o_out_data.out_gain_p), 32'(w.out_gain_p));
                if (o_out_data.out_gain_d !== w.out_gain_d)
                    report("out_gain_d", 32'(o_out_data.out_gain_d), 32'(w.out_gain_d));
                if (o_out_data.out_effort !== w.out_effort)
                    report("out_effort", o_out_data.out_effort, w.out_effort);
                if (o_out_data.last_joint !== w.last_joint)
                    report("last_joint", 32'(o_out_data.last_joint), 32'(w.last_joint));
                if (o_out_data.success !== w.success)
                    report("success", 32'(o_out_data.success), 32'(w.success));
                if (o_out_data.mode_now !== w.mode_now)
                    report("mode_now", 32'(o_out_data.mode_now), 32'(w.mode_now));
                if (o_out_data.machine_state !== w.machine_state)
                    report("machine_state", 32'(o_out_data.machine_state),
                           32'(w.machine_state));
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles > 1000000) begin
            $display("leg_command_supervisor_top verification failed");
            $finish;
        end
    end

    function automatic t_in_item beat(t_cmd c, int j, logic last);
        t_in_item it;
        it.command = c;
        it.joint_index = j[3:0];
        it.last_element = last;
        it.position = $urandom;
        it.velocity = $urandom;
        it.gain_p = 31'($urandom);
        it.gain_d = 31'($urandom);
        it.effort = $urandom;
        it.req_mode = 2'($urandom_range(3));
        return it;
    endfunction

    // A message writes a run of joints; the last one carries the end mark.
    task automatic queue_message(t_cmd c, int n);
        int j;
        for (int k = 0; k < n; k++) begin
            j = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(11);
            pending_beats.push_back(beat(c, j, k == n - 1));
        end
    endtask

    task automatic wait_idle();
        while (pending_beats.size() > 0 || i_in_valid || expected_beats.size() > 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_cfg(t_cfg_idx idx, logic [30:0] value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        t_in_item it;
        int       budget;
        int       r;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_cfg(CFG_TRQ_BOUND, TRQ_BOUND_RST);
        write_cfg(CFG_MAX_REPEAT, 31'(MAX_REPEAT_RST));
        write_cfg(CFG_DAMPING_GAIN, DAMPING_GAIN_RST);
        write_cfg(CFG_HOLD_GAIN_P, 31'h0001_8000);
        write_cfg(CFG_HOLD_GAIN_D, 31'h0000_4000);

        // Every store gets filled before any tick can read it back.
        pending_beats.push_back(beat(CMD_DAMP, 0, 1'b0));
        for (int j = 0; j < JOINT_COUNT; j++)
            pending_beats.push_back(beat(CMD_HOLD, j, j == JOINT_COUNT - 1));
        for (int j = 0; j < JOINT_COUNT; j++) begin
            it = beat(CMD_CMDEL, j, j == JOINT_COUNT - 1);
            if (j < 4) begin
                it.position = (j % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF;
                it.velocity = (j % 2) ? 32'h7FFF_FFFF : 32'h8000_0000;
                it.gain_p = (j < 2) ? 31'h7FFF_FFFF : '0;
                it.gain_d = (j < 2) ? 31'h7FFF_FFFF : '0;
                it.effort = (j % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end
            pending_beats.push_back(it);
        end
        for (int j = 0; j < JOINT_COUNT; j++) begin
            it = beat(CMD_MEAS, j, j == JOINT_COUNT - 1);
            if (j < 4) begin
                it.position = (j % 2) ? 32'h7FFF_FFFF : 32'h8000_0000;
                it.velocity = (j % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end
            pending_beats.push_back(it);
        end
        pending_beats.push_back(beat(CMD_TICK, 0, 1'b0));
        pending_beats.push_back(beat(CMD_TICK, 0, 1'b0));
        for (int m = 1; m <= 3; m++) begin
            it = beat(CMD_MODE, 0, 1'b0);
            it.req_mode = m[1:0];
            pending_beats.push_back(it);
        end
        pending_beats.push_back(beat(CMD_TICK, 0, 1'b0));
        pending_beats.push_back(beat(CMD_DAMP, 0, 1'b0));
        pending_beats.push_back(beat(CMD_EMERG, 0, 1'b0));
        pending_beats.push_back(beat(CMD_TICK, 0, 1'b0));
        pending_beats.push_back(beat(CMD_HDFLT, 0, 1'b0));
        pending_beats.push_back(beat(CMD_DAMP, 0, 1'b0));
        pending_beats.push_back(beat(CMD_DFLT, 0, 1'b0));
        pending_beats.push_back(beat(CMD_DFLT, 15, 1'b0));
        pending_beats.push_back(beat(t_cmd'(4'd9), 0, 1'b0));
        pending_beats.push_back(beat(t_cmd'(4'd15), 0, 1'b0));
        pending_beats.push_back(beat(CMD_CMDEL, 13, 1'b1));
        pending_beats.push_back(beat(CMD_TICK, 0, 1'b0));
        pending_beats.push_back(beat(CMD_TICK, 0, 1'b0));
        pending_beats.push_back(beat(CMD_HDFLT, 0, 1'b0));
        pending_beats.push_back(beat(CMD_TICK, 0, 1'b0));
        wait_idle();

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin
                    write_cfg(CFG_TRQ_BOUND, 31'h7FFF_FFFF);
                    write_cfg(CFG_MAX_REPEAT, 31'd3);
                    write_cfg(CFG_DAMPING_GAIN, 31'h7FFF_FFFF);
                    write_cfg(CFG_HOLD_GAIN_P, 31'h7FFF_FFFF);
                    write_cfg(CFG_HOLD_GAIN_D, 31'h7FFF_FFFF);
                end
                1: begin
                    write_cfg(CFG_TRQ_BOUND, '0);
                    write_cfg(CFG_MAX_REPEAT, '0);
                    write_cfg(CFG_DAMPING_GAIN, '0);
                    write_cfg(CFG_HOLD_GAIN_P, '0);
                    write_cfg(CFG_HOLD_GAIN_D, '0);
                end
                2: begin
                    write_cfg(CFG_TRQ_BOUND, 31'd196608);
                    write_cfg(CFG_MAX_REPEAT, 31'd1023);
                    no_idle = 1'b1;
                end
                3: begin
                    write_cfg(CFG_TRQ_BOUND, 31'($urandom));
                    write_cfg(CFG_MAX_REPEAT, 31'($urandom_range(8, 2)));
                    write_cfg(CFG_DAMPING_GAIN, 31'($urandom));
                    no_idle = 1'b0;
                    long_hold_req = 1'b1;
                end
                default: begin
                    write_cfg(CFG_HOLD_GAIN_P, 31'($urandom));
                    write_cfg(CFG_HOLD_GAIN_D, 31'($urandom));
                    write_cfg(CFG_MAX_REPEAT, 31'd6);
                end
            endcase
            budget = 0;
            while (budget < 42) begin
                r = $urandom_range(99);
                if (r < 36) begin
                    pending_beats.push_back(beat(CMD_TICK, 0, 1'b0));
                    budget++;
                end else if (r < 52) begin
                    r = $urandom_range(6, 1);
                    queue_message(CMD_CMDEL, r);
                    budget += r;
                end else if (r < 64) begin
                    r = $urandom_range(4, 1);
                    queue_message(CMD_MEAS, r);
                    budget += r;
                end else if (r < 68) begin
                    r = $urandom_range(3, 1);
                    queue_message(CMD_HOLD, r);
                    budget += r;
                end else begin
                    case ($urandom_range(6))
                        0: pending_beats.push_back(beat(CMD_HDFLT, 0, 1'b0));
                        1: pending_beats.push_back(beat(CMD_DAMP, 0, 1'b0));
                        2: pending_beats.push_back(beat(CMD_EMERG, 0, 1'b0));
                        3, 4: pending_beats.push_back(beat(CMD_MODE, 0, 1'b0));
                        5: pending_beats.push_back(beat(CMD_DFLT, $urandom_range(15), 1'b0));
                        default: pending_beats.push_back(beat(t_cmd'($urandom_range(15, 9)),
                                                              $urandom_range(15), 1'b1));
                    endcase
                    budget++;
                end
            end
            wait_idle();
        end

        if (errors == 0) begin
            $display("leg_command_supervisor_top verification clean");
        end else begin
            $display("leg_command_supervisor_top verification failed");
        end
        $finish;
    end

endmodule
